### design/stcf_pkg.sv
// Shared types and constants for the stationary target capture block.
`timescale 1ns / 1ps
package stcf_pkg;

    localparam int COORD_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int NUM_CORNERS = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DWELL_W    = 16;
    localparam int THR_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_DWELL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_DWELL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR  = 2'd3;

    localparam logic [DWELL_W-1:0] READY_DWELL_RST = 16'd500;
    localparam logic [DWELL_W-1:0] STILL_DWELL_RST = 16'd4000;
    localparam logic [THR_W-1:0]   MOTION_THR_RST  = 10'd80;

    // squared distance, padded to an even width for the root unit
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int SQP_W   = SQ_W + (SQ_W % 2);
    localparam int ROOT_W  = SQP_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int ITER_W  = $clog2(ROOT_W + 1);
    localparam int MOT_W   = ROOT_W + $clog2(NUM_CORNERS);
    localparam int SCALE_W = 12;
    localparam int PROD_W  = MOT_W + SCALE_W;
    localparam int DIST_W  = $clog2(2 * NUM_CORNERS);

    localparam logic [SCALE_W-1:0] MOTION_SCALE = 12'd4000;

    typedef enum logic [1:0] {
        MODE_READY      = 2'd0,
        MODE_TRACKING   = 2'd1,
        MODE_STATIONARY = 2'd2,
        MODE_CAPTURED   = 2'd3
    } stcf_mode_t;

    typedef struct packed {
        logic       load_in;
        logic       clr_acc;
        logic       sq_x;
        logic       sq_y;
        logic       root_start;
        logic       acc;
        logic       sel_side;
        logic       mul_m;
        logic       mul_t;
        logic       store_prev;
        logic       set_last_empty;
        logic       set_still_start;
        logic       load_out;
        stcf_mode_t out_mode;
        logic       out_capture;
        logic       out_still;
    } stcf_cmd_t;

    typedef struct packed {
        logic present;
        logic ready_ok;
        logic dwell_ok;
        logic still_ok;
        logic root_busy;
    } stcf_status_t;

endpackage

### design/stcf_isqrt.sv
// Floor integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module stcf_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stcf_pkg::SQP_W-1:0]  value,
    output logic                        busy,
    output logic [stcf_pkg::ROOT_W-1:0] root
);
    import stcf_pkg::*;

    logic [SQP_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], val_reg[SQP_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        ge        = rem_sh >= trial;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[SQP_W-3:0], 2'b00};
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### design/stcf_dpath.sv
// Datapath: frame registers, corner store, distance pipeline, timers and result register.
`timescale 1ns / 1ps
module stcf_dpath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [stcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                     in_present,
    input  logic [stcf_pkg::TIME_BITS-1:0] in_time,
    input  logic [stcf_pkg::NUM_CORNERS-1:0][stcf_pkg::COORD_BITS-1:0] in_cx,
    input  logic [stcf_pkg::NUM_CORNERS-1:0][stcf_pkg::COORD_BITS-1:0] in_cy,
    input  stcf_pkg::stcf_cmd_t      cmd,
    output stcf_pkg::stcf_status_t   status,
    output logic [1:0]               mode,
    output logic                     capture_now,
    output logic                     still_frame,
    output logic [31:0]              still_elapsed_ms
);
    import stcf_pkg::*;

    logic [DWELL_W-1:0]   ready_dwell_reg;
    logic [DWELL_W-1:0]   still_dwell_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [TIME_BITS-1:0] last_empty_reg;
    logic [TIME_BITS-1:0] still_start_reg;

    logic                 present_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic [NUM_CORNERS-1:0][COORD_BITS-1:0] cx_reg, cy_reg, px_reg, py_reg;

    logic [SQP_W-1:0]  sq_reg;
    logic [MOT_W-1:0]  motion_reg;
    logic [ROOT_W-1:0] side_reg;
    logic [PROD_W-1:0] pm_reg, pt_reg;

    logic [1:0]  mode_out_reg;
    logic        cap_out_reg;
    logic        still_out_reg;
    logic [31:0] elapsed_out_reg;

    logic [COORD_BITS-1:0]   bx, by, dx, dy, sq_op;
    logic [2*COORD_BITS-1:0] prod;
    logic                    root_busy;
    logic [ROOT_W-1:0]       root;
    logic [TIME_BITS-1:0]    ready_diff, still_diff, still_base, out_diff;

    stcf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .value (sq_reg),
        .busy  (root_busy),
        .root  (root)
    );

    always_comb
    begin
        bx    = cmd.sel_side ? cx_reg[1] : px_reg[0];
        by    = cmd.sel_side ? cy_reg[1] : py_reg[0];
        dx    = (cx_reg[0] > bx) ? cx_reg[0] - bx : bx - cx_reg[0];
        dy    = (cy_reg[0] > by) ? cy_reg[0] - by : by - cy_reg[0];
        sq_op = cmd.sq_y ? dy : dx;
        prod  = sq_op * sq_op;

        ready_diff = t_reg - last_empty_reg;
        still_diff = t_reg - still_start_reg;
        still_base = cmd.set_still_start ? t_reg : still_start_reg;
        out_diff   = t_reg - still_base;

        status.present   = present_reg;
        status.ready_ok  = ready_diff >= TIME_BITS'(ready_dwell_reg);
        status.dwell_ok  = still_diff > TIME_BITS'(still_dwell_reg);
        status.still_ok  = (side_reg != '0) && (pm_reg < pt_reg);
        status.root_busy = root_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_dwell_reg <= READY_DWELL_RST;
            still_dwell_reg <= STILL_DWELL_RST;
            thr_reg         <= MOTION_THR_RST;
            last_empty_reg  <= '0;
            still_start_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_TIME:  last_empty_reg  <= TIME_BITS'(cfg_wdata);
                    CFG_READY_DWELL: ready_dwell_reg <= DWELL_W'(cfg_wdata);
                    CFG_STILL_DWELL: still_dwell_reg <= DWELL_W'(cfg_wdata);
                    CFG_MOTION_THR:  thr_reg         <= THR_W'(cfg_wdata);
                    default: ;
                endcase
            end
            if (cmd.set_last_empty)
            begin
                last_empty_reg <= t_reg;
            end
            if (cmd.set_still_start)
            begin
                still_start_reg <= t_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            present_reg <= in_present;
            t_reg       <= in_time;
            cx_reg      <= in_cx;
            cy_reg      <= in_cy;
        end
        else if (cmd.acc)
        begin
            // rotate so the next corner sits at the fixed taps
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                cx_reg[i] <= cx_reg[(i + 1) % NUM_CORNERS];
                cy_reg[i] <= cy_reg[(i + 1) % NUM_CORNERS];
                if (!cmd.sel_side)
                begin
                    px_reg[i] <= px_reg[(i + 1) % NUM_CORNERS];
                    py_reg[i] <= py_reg[(i + 1) % NUM_CORNERS];
                end
            end
        end
        if (cmd.store_prev)
        begin
            px_reg <= cx_reg;
            py_reg <= cy_reg;
        end

        if (cmd.sq_x)
        begin
            sq_reg <= SQP_W'(prod);
        end
        else if (cmd.sq_y)
        begin
            sq_reg <= sq_reg + SQP_W'(prod);
        end

        if (cmd.clr_acc)
        begin
            motion_reg <= '0;
            side_reg   <= '0;
        end
        else if (cmd.acc)
        begin
            if (cmd.sel_side)
            begin
                if (root > side_reg)
                begin
                    side_reg <= root;
                end
            end
            else
            begin
                motion_reg <= motion_reg + MOT_W'(root);
            end
        end

        if (cmd.mul_m)
        begin
            pm_reg <= PROD_W'(motion_reg) * PROD_W'(MOTION_SCALE);
        end
        if (cmd.mul_t)
        begin
            pt_reg <= PROD_W'(thr_reg) * PROD_W'(side_reg);
        end

        if (cmd.load_out)
        begin
            mode_out_reg    <= cmd.out_mode;
            cap_out_reg     <= cmd.out_capture;
            still_out_reg   <= cmd.out_still;
            elapsed_out_reg <= (cmd.out_mode == MODE_STATIONARY) ? 32'(out_diff) : 32'd0;
        end
    end

    assign mode             = mode_out_reg;
    assign capture_now      = cap_out_reg;
    assign still_frame      = still_out_reg;
    assign still_elapsed_ms = elapsed_out_reg;

endmodule

### design/stcf_ctrl.sv
// Controller: mode register, distance sequencing and handshakes.
`timescale 1ns / 1ps
module stcf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  stcf_pkg::stcf_status_t status,
    output stcf_pkg::stcf_cmd_t    cmd
);
    import stcf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQX,
        S_SQY,
        S_START,
        S_ROOT,
        S_ACC,
        S_MULM,
        S_MULT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [DIST_W-1:0] j_reg, j_next;
    stcf_mode_t        mode_reg, mode_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.out_mode   = mode_reg;
        cmd.sel_side   = j_reg[DIST_W-1];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.clr_acc = 1'b1;
                j_next      = '0;
                if (status.present &&
                    (mode_reg == MODE_TRACKING || mode_reg == MODE_STATIONARY))
                begin
                    state_next = S_SQX;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (!status.root_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                j_next  = j_reg + 1'b1;
                if (j_reg == DIST_W'(2 * NUM_CORNERS - 1))
                begin
                    state_next = S_MULM;
                end
                else
                begin
                    state_next = S_SQX;
                end
            end
            S_MULM:
            begin
                cmd.mul_m  = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mul_t  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the decision until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    if (!status.present)
                    begin
                        mode_next          = MODE_READY;
                        cmd.set_last_empty = 1'b1;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_READY:
                            begin
                                if (status.ready_ok)
                                begin
                                    mode_next      = MODE_TRACKING;
                                    cmd.store_prev = 1'b1;
                                end
                            end
                            MODE_TRACKING:
                            begin
                                cmd.store_prev = 1'b1;
                                if (status.still_ok)
                                begin
                                    cmd.out_still       = 1'b1;
                                    cmd.set_still_start = 1'b1;
                                    mode_next           = MODE_STATIONARY;
                                end
                            end
                            MODE_STATIONARY:
                            begin
                                cmd.store_prev = 1'b1;
                                if (!status.still_ok)
                                begin
                                    mode_next = MODE_TRACKING;
                                end
                                else
                                begin
                                    cmd.out_still = 1'b1;
                                    if (status.dwell_ok)
                                    begin
                                        mode_next       = MODE_CAPTURED;
                                        cmd.out_capture = 1'b1;
                                    end
                                end
                            end
                            MODE_CAPTURED: ;
                            default: ;
                        endcase
                    end
                    cmd.out_mode   = mode_next;
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            mode_reg      <= MODE_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### design/stationary_target_capture_fsm_top.sv
// Top level of the stationary target capture controller.
`timescale 1ns / 1ps
// Takes one camera frame per item and returns one result item per frame: the
// mode after the frame (ready, tracking, stationary, captured), a capture
// strobe, the stillness test result and the time spent stationary. A frame in
// tracking or stationary mode with the board present runs eight corner
// distances through one shared square-root unit that makes one root bit per
// cycle; any other frame goes straight to the decision. The next frame is
// accepted while a result still waits in the output register. Configuration
// writes are registered and are only to be made while no frame is in flight.
module stationary_target_capture_fsm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [stcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        board_present,
    input  logic [31:0] time_ms,
    input  logic [15:0] corner0_x,
    input  logic [15:0] corner0_y,
    input  logic [15:0] corner1_x,
    input  logic [15:0] corner1_y,
    input  logic [15:0] corner2_x,
    input  logic [15:0] corner2_y,
    input  logic [15:0] corner3_x,
    input  logic [15:0] corner3_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  mode,
    output logic        capture_now,
    output logic        still_frame,
    output logic [31:0] still_elapsed_ms
);
    import stcf_pkg::*;

    stcf_cmd_t    cmd;
    stcf_status_t status;
    logic [NUM_CORNERS-1:0][COORD_BITS-1:0] cx, cy;
    logic [TIME_BITS-1:0] t_in;

    assign t_in  = TIME_BITS'(time_ms);
    assign cx[0] = COORD_BITS'(corner0_x);
    assign cy[0] = COORD_BITS'(corner0_y);
    assign cx[1] = COORD_BITS'(corner1_x);
    assign cy[1] = COORD_BITS'(corner1_y);
    assign cx[2] = COORD_BITS'(corner2_x);
    assign cy[2] = COORD_BITS'(corner2_y);
    assign cx[3] = COORD_BITS'(corner3_x);
    assign cy[3] = COORD_BITS'(corner3_y);

    stcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    stcf_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_present       (board_present),
        .in_time          (t_in),
        .in_cx            (cx),
        .in_cy            (cy),
        .cmd              (cmd),
        .status           (status),
        .mode             (mode),
        .capture_now      (capture_now),
        .still_frame      (still_frame),
        .still_elapsed_ms (still_elapsed_ms)
    );

endmodule

### design/stcf_chk.sv
// Port-level checker for the stationary target capture controller, with its bind.
`timescale 1ns / 1ps
module stcf_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  mode,
    input logic        capture_now,
    input logic        still_frame,
    input logic [31:0] still_elapsed_ms
);
    import stcf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode) &&
        $stable(still_elapsed_ms))
        else $error("result item changed while stalled");

    a_capture_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && capture_now |-> mode == MODE_CAPTURED && still_frame)
        else $error("capture strobe outside a still captured frame");

    a_elapsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode != MODE_STATIONARY |-> still_elapsed_ms == 32'd0)
        else $error("elapsed time reported outside stationary mode");

    a_still_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == MODE_STATIONARY |-> still_frame)
        else $error("stationary mode without a still frame");

endmodule

bind stationary_target_capture_fsm_top stcf_chk u_stcf_chk (.*);

### tb/tb_top.sv
// Testbench for the stationary target capture controller.
`timescale 1ns / 1ps
module tb_top;
    import stcf_pkg::*;

    typedef struct packed {
        logic [1:0]  mode;
        logic        capture;
        logic        still;
        logic [31:0] elapsed;
    } frame_result_t;

    typedef struct {
        logic        present;
        logic [31:0] t;
        logic [15:0] c [8];
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        board_present;
    logic [31:0] time_ms;
    logic [15:0] cx [8];
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  mode;
    logic        capture_now;
    logic        still_frame;
    logic [31:0] still_elapsed_ms;

    // predictor state
    logic [15:0] p_ready_dwell;
    logic [15:0] p_still_dwell;
    logic [9:0]  p_thr;
    stcf_mode_t  p_mode;
    logic [15:0] p_prev [8];
    logic [31:0] p_last_empty;
    logic [31:0] p_still_start;

    frame_result_t expected_results[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    logic [31:0] now_ms;

    localparam int WATCHDOG = 20000;

    stationary_target_capture_fsm_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .board_present(board_present), .time_ms(time_ms),
        .corner0_x(cx[0]), .corner0_y(cx[1]), .corner1_x(cx[2]), .corner1_y(cx[3]),
        .corner2_x(cx[4]), .corner2_y(cx[5]), .corner3_x(cx[6]), .corner3_y(cx[7]),
        .out_valid(out_valid), .out_ready(out_ready),
        .mode(mode), .capture_now(capture_now), .still_frame(still_frame),
        .still_elapsed_ms(still_elapsed_ms)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] corner_dist(input logic [15:0] ax, input logic [15:0] ay,
                                                input logic [15:0] bx, input logic [15:0] by);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return isqrt(dx * dx + dy * dy);
    endfunction

    // compare against stored corners, then store the new ones
    function automatic bit test_stillness(input frame_t f);
        logic [63:0] motion;
        logic [63:0] side;
        logic [63:0] s;
        int n;
        motion = 0;
        side = 0;
        for (int k = 0; k < 4; k++)
        begin
            n = (k + 1) % 4;
            motion += corner_dist(f.c[2*k], f.c[2*k+1], p_prev[2*k], p_prev[2*k+1]);
            s = corner_dist(f.c[2*k], f.c[2*k+1], f.c[2*n], f.c[2*n+1]);
            if (s > side) side = s;
        end
        for (int k = 0; k < 8; k++) p_prev[k] = f.c[k];
        if (side == 0) return 1'b0;
        return motion * 4000 < p_thr * side;
    endfunction

    function automatic frame_result_t predict_frame(input frame_t f);
        frame_result_t r;
        r = '0;
        if (!f.present)
        begin
            p_last_empty = f.t;
            p_mode = MODE_READY;
        end
        else
            case (p_mode)
                MODE_READY:
                    if (f.t - p_last_empty >= {16'd0, p_ready_dwell})
                    begin
                        p_mode = MODE_TRACKING;
                        for (int k = 0; k < 8; k++) p_prev[k] = f.c[k];
                    end
                MODE_TRACKING:
                    if (test_stillness(f))
                    begin
                        r.still = 1'b1;
                        p_mode = MODE_STATIONARY;
                        p_still_start = f.t;
                    end
                MODE_STATIONARY:
                    if (!test_stillness(f))
                        p_mode = MODE_TRACKING;
                    else
                    begin
                        r.still = 1'b1;
                        if (f.t - p_still_start > {16'd0, p_still_dwell})
                        begin
                            p_mode = MODE_CAPTURED;
                            r.capture = 1'b1;
                        end
                    end
                default: ;
            endcase
        if (p_mode == MODE_STATIONARY) r.elapsed = f.t - p_still_start;
        r.mode = p_mode;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_TIME:  p_last_empty = val;
            CFG_READY_DWELL: p_ready_dwell = val[15:0];
            CFG_STILL_DWELL: p_still_dwell = val[15:0];
            CFG_MOTION_THR:  p_thr = val[9:0];
            default: ;
        endcase
    endtask

    // wait for all results, then let the block settle before a write
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic send_frame(input frame_t f);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        board_present <= f.present;
        time_ms       <= f.t;
        for (int k = 0; k < 8; k++) cx[k] <= f.c[k];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(predict_frame(f));
        @(negedge clk);
    endtask

    function automatic frame_t make_square(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] sz, input int jitter);
        frame_t f;
        f.present = 1'b1;
        f.t = now_ms;
        f.c[0] = x;      f.c[1] = y;
        f.c[2] = x + sz; f.c[3] = y;
        f.c[4] = x + sz; f.c[5] = y + sz;
        f.c[6] = x;      f.c[7] = y + sz;
        for (int k = 0; k < 8; k++)
            if (jitter > 0) f.c[k] = f.c[k] + $urandom_range(0, jitter);
        return f;
    endfunction

    function automatic frame_t make_empty();
        frame_t f;
        f.present = 1'b0;
        f.t = now_ms;
        for (int k = 0; k < 8; k++) f.c[k] = $urandom;
        return f;
    endfunction

    task automatic test_directed();
        frame_t f;
        now_ms = 32'd100;
        send_frame(make_empty());
        now_ms = 32'd599;
        send_frame(make_square(1000, 1000, 800, 0));   // one short of ready dwell
        now_ms = 32'd600;
        send_frame(make_square(1000, 1000, 800, 0));   // exactly ready dwell
        now_ms = 32'd700;
        f = make_square(1000, 1000, 0, 0);              // zero longest side
        send_frame(f);
        send_frame(f);
        now_ms = 32'd800;
        send_frame(make_square(1000, 1000, 800, 0));
        now_ms = 32'd900;
        send_frame(make_square(1000, 1000, 800, 0));   // becomes stationary
        now_ms = 32'd4900;
        send_frame(make_square(1000, 1000, 800, 0));   // exactly dwell, no capture
        now_ms = 32'd4901;
        send_frame(make_square(1000, 1000, 800, 0));   // capture
        send_frame(make_square(0, 0, 16'hffff, 0));     // stay captured
        send_frame(make_empty());
        now_ms = 32'hffff_fff0;
        send_frame(make_square(16'hffff, 16'hffff, 0, 0));
        now_ms = 32'h0000_0100;                         // wrap forward
        send_frame(make_square(0, 0, 16'hffff, 0));
        send_frame(make_square(16'hffff, 16'hffff, 16'h0001, 0));
        now_ms = 32'h0000_0050;                         // backwards in time
        send_frame(make_square(0, 0, 16'hffff, 0));
        send_frame(make_square(0, 0, 16'hffff, 0));
        now_ms = 32'h0000_0010;
        send_frame(make_square(0, 0, 16'hffff, 0));
        drain();
    endtask

    task automatic run_random(input int count);
        frame_t f;
        logic [15:0] bx, by, sz;
        int r;
        int jit;
        bx = $urandom; by = $urandom; sz = $urandom_range(16, 4000);
        jit = $urandom_range(0, 6);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            now_ms += (r < 90) ? $urandom_range(0, 700) : $urandom;
            if (r < 6)
            begin
                f = make_empty();
                bx = $urandom; by = $urandom; sz = $urandom_range(16, 4000);
                jit = $urandom_range(0, 6);
            end
            else if (r < 12)
            begin
                f = make_square(0, 0, 0, 0);
                for (int k = 0; k < 8; k++) f.c[k] = $urandom;
                f.present = 1'b1;
            end
            else if (r < 18)
                f = make_square(bx, by, sz, $urandom_range(20, 400));
            else
                f = make_square(bx, by, sz, jit);
            send_frame(f);
        end
        drain();
    endtask

    task automatic test_default_config();
        run_random(250);
    endtask

    task automatic test_low_extremes();
        write_reg(CFG_START_TIME, 32'd0);
        write_reg(CFG_READY_DWELL, 32'd0);
        write_reg(CFG_STILL_DWELL, 32'd0);
        write_reg(CFG_MOTION_THR, 32'd0);
        now_ms = $urandom;
        run_random(150);
    endtask

    task automatic test_high_extremes();
        write_reg(CFG_START_TIME, 32'hffff_ffff);
        write_reg(CFG_READY_DWELL, 32'h0000_ffff);
        write_reg(CFG_STILL_DWELL, 32'h0000_ffff);
        write_reg(CFG_MOTION_THR, 32'h0000_03ff);
        now_ms = 32'hffff_0000;
        run_random(200);
    endtask

    task automatic test_random_config();
        for (int p = 0; p < 3; p++)
        begin
            write_reg(CFG_START_TIME, $urandom);
            write_reg(CFG_READY_DWELL, $urandom_range(0, 1500));
            write_reg(CFG_STILL_DWELL, $urandom_range(0, 3000));
            write_reg(CFG_MOTION_THR, $urandom_range(0, 1023));
            now_ms = $urandom;
            run_random(100);
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 15) < 11) || (($time / 20000) % 3 == 0);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            frame_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result mode=%0d", mode);
            end
            else
            begin
                want = expected_results.pop_front();
                if (mode !== want.mode || capture_now !== want.capture ||
                    still_frame !== want.still || still_elapsed_ms !== want.elapsed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: exp mode=%0d cap=%0b still=%0b el=%0d got %0d %0b %0b %0d",
                                 want.mode, want.capture, want.still, want.elapsed,
                                 mode, capture_now, still_frame, still_elapsed_ms);
                end
            end
        end

    always @(posedge clk)
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Mismatches found");
                $finish;
            end
        end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        board_present = 1'b0;
        time_ms = '0;
        for (int k = 0; k < 8; k++) cx[k] = '0;
        mismatches = 0;
        burst_left = 0;
        p_ready_dwell = READY_DWELL_RST;
        p_still_dwell = STILL_DWELL_RST;
        p_thr = MOTION_THR_RST;
        p_mode = MODE_READY;
        for (int k = 0; k < 8; k++) p_prev[k] = '0;
        p_last_empty = 0;
        p_still_start = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_default_config();
        test_low_extremes();
        test_high_extremes();
        test_random_config();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### stationary_target_capture_fsm_top.f
design/stcf_pkg.sv
design/stcf_isqrt.sv
design/stcf_dpath.sv
design/stcf_ctrl.sv
design/stationary_target_capture_fsm_top.sv
design/stcf_chk.sv
tb/tb_top.sv
